// ----- hw/rtl/plt_pkg.sv -----
// shared types, sizes and codes for the packed list table
`default_nettype none

package plt_pkg;

    localparam int CAPACITY = 64;
    localparam int DATA_W   = 32;
    localparam int POS_W    = 7;
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int WIDE_W   = CNT_W + POS_W;
    localparam int GRP      = 8;
    localparam int GRP_W    = $clog2(GRP);
    localparam int NGROUP   = (CAPACITY + GRP - 1) / GRP;

    typedef enum logic [1:0] {
        REQ_FIND   = 2'd0,
        REQ_MODIFY = 2'd1,
        REQ_APPEND = 2'd2,
        REQ_REMOVE = 2'd3
    } t_req;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOOK,
        S_GROUP,
        S_DONE
    } t_state;

    typedef struct packed {
        logic live;
        logic sel;
        logic wr;
        logic shift;
    } t_cell_ctl;

    typedef struct packed {
        logic              any;
        logic [GRP_W-1:0]  first;
        logic [DATA_W-1:0] rdata;
    } t_grp_res;

endpackage

`default_nettype wire

// ----- hw/rtl/packed_list_table_top.sv -----
// top level of the packed list table: request sequencer, cell chain and reductions
`default_nettype none

// packed list of up to 64 signed 32-bit entries held in a chain of cells,
// one entry per cell, plus an entry count. each request (find, modify,
// append, remove) runs in steps from input transfer to a loaded result:
// every cell compares its entry and registers its read value, then the
// per-group reduction of eight cells is registered, then the final
// priority pick, the status and the chain update follow. a new request is
// taken only when the sequencer is idle, once the last one has finished
// its update step; the result register lets the next request enter while
// a result still waits, and the update step waits only if that register
// is still full and the output is stalled. remove shifts all later cells
// down at once, each cell loading from its upper neighbor. no clearing
// pass runs after reset; entries beyond the count are never read.
module packed_list_table_top (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [1:0]  i_req_type,
    input  wire logic [6:0]  i_position,
    input  wire logic [31:0] i_value,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [1:0]       o_status,
    output logic             o_hit,
    output logic [5:0]       o_hit_position,
    output logic [31:0]      o_old_value,
    output logic [6:0]       o_count_now
);

    localparam int NCELL = plt_pkg::NGROUP * plt_pkg::GRP;

    // sequencer and latched request
    plt_pkg::t_state                  r_state, n_state;
    plt_pkg::t_req                    r_type;
    logic [plt_pkg::POS_W-1:0]        r_pos;
    logic [plt_pkg::DATA_W-1:0]       r_val;
    logic [plt_pkg::CNT_W-1:0]        r_count, n_count;

    // result register
    logic                             r_out_valid, n_out_valid;
    plt_pkg::t_status                 r_status, n_status;
    logic                             r_hit, n_hit;
    logic [plt_pkg::IDX_W-1:0]        r_hpos, n_hpos;
    logic [plt_pkg::DATA_W-1:0]       r_old, n_old;

    logic                             accept;
    logic                             finish;
    logic                             pos_oor;
    logic                             full;
    logic                             do_modify;
    logic                             do_append;
    logic                             do_remove;

    // chain wiring, padded up to whole groups
    plt_pkg::t_cell_ctl               w_ctl [plt_pkg::CAPACITY];
    logic [plt_pkg::DATA_W-1:0]       w_data [plt_pkg::CAPACITY];
    logic [NCELL-1:0]                 w_match;
    logic [NCELL-1:0][plt_pkg::DATA_W-1:0] w_rd;
    plt_pkg::t_grp_res                w_grp [plt_pkg::NGROUP];

    // final reduction over the groups
    logic                             f_any;
    logic [plt_pkg::IDX_W-1:0]        f_hpos;
    logic [plt_pkg::DATA_W-1:0]       f_old;

    assign accept     = i_in_valid && (r_state == plt_pkg::S_IDLE);
    assign o_in_stall = (r_state != plt_pkg::S_IDLE);
    assign finish     = (r_state == plt_pkg::S_DONE) && (!r_out_valid || !i_out_stall);

    assign pos_oor = plt_pkg::WIDE_W'(r_pos) >= plt_pkg::WIDE_W'(r_count);
    assign full    = r_count >= plt_pkg::CNT_W'(plt_pkg::CAPACITY);

    assign do_modify = finish && (r_type == plt_pkg::REQ_MODIFY) && !pos_oor;
    assign do_append = finish && (r_type == plt_pkg::REQ_APPEND) && !full;
    assign do_remove = finish && (r_type == plt_pkg::REQ_REMOVE) && !pos_oor;

    // the cell chain
    for (genvar gi = 0; gi < plt_pkg::CAPACITY; gi++) begin : g_cell
        logic [plt_pkg::DATA_W-1:0] next_data;
        logic                       at_pos;
        logic                       above_pos;

        assign at_pos    = plt_pkg::WIDE_W'(r_pos) == plt_pkg::WIDE_W'(gi);
        assign above_pos = plt_pkg::WIDE_W'(gi) >= plt_pkg::WIDE_W'(r_pos);

        assign w_ctl[gi].live  = plt_pkg::CNT_W'(gi) < r_count;
        assign w_ctl[gi].sel   = at_pos;
        // modify writes the addressed cell, append writes the first free cell
        assign w_ctl[gi].wr    = (do_modify && at_pos)
                              || (do_append && (plt_pkg::CNT_W'(gi) == r_count));
        // remove: every live cell from the position upward takes its neighbor
        assign w_ctl[gi].shift = do_remove && above_pos && w_ctl[gi].live;

        if (gi == plt_pkg::CAPACITY - 1) begin : g_last
            assign next_data = '0;
        end else begin : g_mid
            assign next_data = w_data[gi+1];
        end

        plt_cell u_cell (
            .i_clk   (i_clk),
            .i_ctl   (w_ctl[gi]),
            .i_key   (r_val),
            .i_wdata (r_val),
            .i_next  (next_data),
            .o_data  (w_data[gi]),
            .o_match (w_match[gi]),
            .o_rd    (w_rd[gi])
        );
    end

    // unused slots of the last group never match
    for (genvar gp = plt_pkg::CAPACITY; gp < NCELL; gp++) begin : g_pad
        assign w_match[gp] = 1'b0;
        assign w_rd[gp]    = '0;
    end

    // first reduction level, eight cells per group
    for (genvar gg = 0; gg < plt_pkg::NGROUP; gg++) begin : g_grp
        plt_group u_group (
            .i_clk   (i_clk),
            .i_match (w_match[gg*plt_pkg::GRP +: plt_pkg::GRP]),
            .i_rd    (w_rd[gg*plt_pkg::GRP +: plt_pkg::GRP]),
            .o_res   (w_grp[gg])
        );
    end

    // lowest group with a hit wins; read data is a plain or
    always_comb begin
        f_any  = 1'b0;
        f_hpos = '0;
        f_old  = '0;
        for (int g = plt_pkg::NGROUP - 1; g >= 0; g--) begin
            if (w_grp[g].any) begin
                f_any  = 1'b1;
                f_hpos = plt_pkg::IDX_W'(g * plt_pkg::GRP) + plt_pkg::IDX_W'(w_grp[g].first);
            end
        end
        for (int g = 0; g < plt_pkg::NGROUP; g++) begin
            f_old = f_old | w_grp[g].rdata;
        end
    end

    // next state, count and result
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_out_valid = r_out_valid;
        n_status    = r_status;
        n_hit       = r_hit;
        n_hpos      = r_hpos;
        n_old       = r_old;

        unique case (r_state)
            plt_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_state = plt_pkg::S_LOOK;
                end
            end
            plt_pkg::S_LOOK: begin
                n_state = plt_pkg::S_GROUP;
            end
            plt_pkg::S_GROUP: begin
                n_state = plt_pkg::S_DONE;
            end
            plt_pkg::S_DONE: begin
                if (finish) begin
                    n_state = plt_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = plt_pkg::S_IDLE;
            end
        endcase

        if (do_append) begin
            n_count = r_count + plt_pkg::CNT_W'(1);
        end else if (do_remove) begin
            n_count = r_count - plt_pkg::CNT_W'(1);
        end

        if (o_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        if (finish) begin
            n_out_valid = 1'b1;
            n_status    = plt_pkg::ST_OK;
            n_hit       = 1'b0;
            n_hpos      = '0;
            n_old       = '0;
            case (r_type)
                plt_pkg::REQ_FIND: begin
                    n_hit  = f_any;
                    n_hpos = f_any ? f_hpos : '0;
                end
                plt_pkg::REQ_MODIFY: begin
                    if (pos_oor) begin
                        n_status = plt_pkg::ST_RANGE;
                    end else begin
                        n_old = f_old;
                    end
                end
                plt_pkg::REQ_APPEND: begin
                    if (full) begin
                        n_status = plt_pkg::ST_FULL;
                    end
                end
                default: begin
                    if (pos_oor) begin
                        n_status = plt_pkg::ST_RANGE;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= plt_pkg::S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    // request and result payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_type <= plt_pkg::t_req'(i_req_type);
            r_pos  <= i_position;
            r_val  <= i_value;
        end
        r_status <= n_status;
        r_hit    <= n_hit;
        r_hpos   <= n_hpos;
        r_old    <= n_old;
    end

    assign o_out_valid    = r_out_valid;
    assign o_status       = r_status;
    assign o_hit          = r_hit;
    assign o_hit_position = 6'(r_hpos);
    assign o_old_value    = r_old;
    assign o_count_now    = 7'(r_count);

    // count never runs past capacity
    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= plt_pkg::CNT_W'(plt_pkg::CAPACITY))
        else $error("entry count above capacity");

    // the count moves only in the update step
    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && (r_count != $past(r_count))) |-> $past(r_state == plt_pkg::S_DONE))
        else $error("entry count changed outside the update step");

    // a new result appears only right after the update step
    a_out_rise: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state == plt_pkg::S_DONE))
        else $error("result valid without an update step");

    // a hit is always ok and lies inside the list
    a_hit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_hit) |->
            (o_status == plt_pkg::ST_OK) && (7'(o_hit_position) < o_count_now))
        else $error("hit outside the list");

endmodule

`default_nettype wire

// ----- hw/rtl/plt_cell.sv -----
// one list entry: storage, compare against the key, selected read, shift from neighbor
`default_nettype none

module plt_cell (
    input  wire logic                       i_clk,
    input  wire plt_pkg::t_cell_ctl         i_ctl,
    input  wire logic [plt_pkg::DATA_W-1:0] i_key,
    input  wire logic [plt_pkg::DATA_W-1:0] i_wdata,
    input  wire logic [plt_pkg::DATA_W-1:0] i_next,
    output logic      [plt_pkg::DATA_W-1:0] o_data,
    output logic                            o_match,
    output logic      [plt_pkg::DATA_W-1:0] o_rd
);

    logic [plt_pkg::DATA_W-1:0] r_data;
    logic                       r_match;
    logic [plt_pkg::DATA_W-1:0] r_rd;

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr) begin
            r_data <= i_wdata;
        end else if (i_ctl.shift) begin
            r_data <= i_next;
        end
        r_match <= i_ctl.live && (r_data == i_key);
        r_rd    <= (i_ctl.live && i_ctl.sel) ? r_data : '0;
    end

    assign o_data  = r_data;
    assign o_match = r_match;
    assign o_rd    = r_rd;

endmodule

`default_nettype wire

// ----- hw/rtl/plt_group.sv -----
// reduces the match and read bits of one group of cells, registered
`default_nettype none

module plt_group (
    input  wire logic                                        i_clk,
    input  wire logic [plt_pkg::GRP-1:0]                     i_match,
    input  wire logic [plt_pkg::GRP-1:0][plt_pkg::DATA_W-1:0] i_rd,
    output plt_pkg::t_grp_res                                o_res
);

    plt_pkg::t_grp_res r_res;
    plt_pkg::t_grp_res n_res;

    always_comb begin
        n_res.any   = |i_match;
        n_res.first = '0;
        n_res.rdata = '0;
        for (int k = plt_pkg::GRP - 1; k >= 0; k--) begin
            if (i_match[k]) begin
                n_res.first = plt_pkg::GRP_W'(k);
            end
        end
        for (int k = 0; k < plt_pkg::GRP; k++) begin
            n_res.rdata = n_res.rdata | i_rd[k];
        end
    end

    always_ff @(posedge i_clk) begin
        r_res <= n_res;
    end

    assign o_res = r_res;

endmodule

`default_nettype wire

// ----- tb/packed_list_table_top_tb.sv -----
// self-checking testbench for the packed list table: directed and random requests, scoreboard
module packed_list_table_top_tb;

    localparam int HOLD_CYCLES    = 300;   // long receiver hold-off, fills the block
    localparam int WATCHDOG_LIMIT = 3000;  // cycles without any transfer before giving up
    localparam int DRAIN_CYCLES   = 20;    // settle time after the last result
    localparam int RAND_PER_PHASE = 270;   // four phases, about 1080 random requests
    localparam int BLOCK_LEN      = 50;    // requests per fill/mixed/drain block
    localparam int POOL_SIZE      = 8;

    // one expected result as the block should report it
    typedef struct {
        plt_pkg::t_status status;
        logic             hit;
        logic [5:0]       hit_position;
        logic [31:0]      old_value;
        logic [6:0]       count_now;
    } t_list_result;

    // mirror of the list plus the queue of results still owed by the block
    class list_scoreboard;
        logic [31:0]  slots[plt_pkg::CAPACITY];
        int           fill;
        int           errors;
        t_list_result pending_results[$];

        function new();
            fill   = 0;
            errors = 0;
        endfunction

        function int occupancy();
            return fill;
        endfunction

        function int pending();
            return pending_results.size();
        endfunction

        // apply one accepted request to the mirror and queue its result
        function void note_request(plt_pkg::t_req req, logic [6:0] pos, logic [31:0] val);
            t_list_result r;
            int           i;
            r.status       = plt_pkg::ST_OK;
            r.hit          = 1'b0;
            r.hit_position = '0;
            r.old_value    = '0;
            case (req)
                plt_pkg::REQ_FIND: begin
                    // lowest matching position wins
                    for (i = 0; i < fill && !r.hit; i++) begin
                        if (slots[i] == val) begin
                            r.hit          = 1'b1;
                            r.hit_position = i[5:0];
                        end
                    end
                end
                plt_pkg::REQ_MODIFY: begin
                    if (int'(pos) >= fill) begin
                        r.status = plt_pkg::ST_RANGE;
                    end else begin
                        r.old_value = slots[pos];
                        slots[pos]  = val;
                    end
                end
                plt_pkg::REQ_APPEND: begin
                    if (fill >= plt_pkg::CAPACITY) begin
                        r.status = plt_pkg::ST_FULL;
                    end else begin
                        slots[fill] = val;
                        fill++;
                    end
                end
                default: begin
                    if (int'(pos) >= fill) begin
                        r.status = plt_pkg::ST_RANGE;
                    end else begin
                        for (i = int'(pos); i + 1 < fill; i++) slots[i] = slots[i + 1];
                        fill--;
                    end
                end
            endcase
            r.count_now = fill[6:0];
            pending_results.push_back(r);
        endfunction

        function void compare_field(string label, logic [31:0] want, logic [31:0] got);
            if (got !== want) begin
                $display("%0t: %s mismatch, expected %h, actual %h", $time, label, want, got);
                errors++;
            end
        endfunction

        // compare one result transfer with the oldest expectation
        function void check_result(logic [1:0] status, logic hit, logic [5:0] hit_position,
                                   logic [31:0] old_value, logic [6:0] count_now);
            t_list_result r;
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual status %h count %0d",
                         $time, status, count_now);
                errors++;
                return;
            end
            r = pending_results.pop_front();
            compare_field("status", 32'(r.status), 32'(status));
            compare_field("hit", 32'(r.hit), 32'(hit));
            compare_field("hit_position", 32'(r.hit_position), 32'(hit_position));
            compare_field("old_value", r.old_value, old_value);
            compare_field("count_now", 32'(r.count_now), 32'(count_now));
        endfunction
    endclass

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_in_valid  = 1'b0;
    logic [1:0]  i_req_type  = '0;
    logic [6:0]  i_position  = '0;
    logic [31:0] i_value     = '0;
    logic        i_out_stall = 1'b0;
    logic        o_in_stall;
    logic        o_out_valid;
    logic [1:0]  o_status;
    logic        o_hit;
    logic [5:0]  o_hit_position;
    logic [31:0] o_old_value;
    logic [6:0]  o_count_now;

    list_scoreboard sb;

    int send_idle_pct  = 0;    // chance per cycle that the sender holds back
    int recv_stall_pct = 0;    // chance per cycle that the receiver stalls
    bit hold_request   = 1'b0; // raised at a rising edge, taken by the receiver
    int hold_left      = 0;
    int quiet_cycles   = 0;

    logic [31:0] value_pool[POOL_SIZE];

    packed_list_table_top dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_req_type     (i_req_type),
        .i_position     (i_position),
        .i_value        (i_value),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_status       (o_status),
        .o_hit          (o_hit),
        .o_hit_position (o_hit_position),
        .o_old_value    (o_old_value),
        .o_count_now    (o_count_now)
    );

    always #5 i_clk = ~i_clk;

    // receiver: random stalls, or a long counted hold-off on request
    always @(negedge i_clk) begin
        if (hold_request) begin
            hold_left    = HOLD_CYCLES;
            hold_request = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // result monitor and watchdog, both sampled at the rising edge
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid === 1'b1 && i_out_stall == 1'b0) begin
            sb.check_result(o_status, o_hit, o_hit_position, o_old_value, o_count_now);
        end
        if ((i_in_valid && o_in_stall === 1'b0) || (o_out_valid === 1'b1 && !i_out_stall)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, quiet_cycles);
            $display("Some tests failed");
            $finish;
        end
    end

    // offer one request, entered and left at a falling edge; the payload holds while stalled
    task automatic send_request(input plt_pkg::t_req req, input logic [6:0] pos,
                                input logic [31:0] val);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_req_type <= req;
        i_position <= pos;
        i_value    <= val;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        sb.note_request(req, pos, val);
        @(negedge i_clk);
    endtask

    // stop offering until every owed result has come back; returns just after a rising edge
    task automatic pause_until_drained();
        i_in_valid <= 1'b0;
        do @(negedge i_clk); while (sb.pending() != 0);
        @(posedge i_clk);
    endtask

    initial begin
        int            phase;
        int            n;
        int            regime;
        int            roll;
        int            count;
        plt_pkg::t_req req;
        logic [6:0]    pos;
        logic [31:0]   val;

        sb = new();
        value_pool[0] = 32'h8000_0000;
        value_pool[1] = 32'h7fff_ffff;
        value_pool[2] = 32'h0000_0000;
        value_pool[3] = 32'hffff_ffff;
        for (n = 4; n < POOL_SIZE; n++) value_pool[n] = $urandom();

        // synchronous reset, released at a falling edge
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: empty list, value extremes, duplicates, range errors, shifts
        send_request(plt_pkg::REQ_FIND,   7'd0,   32'h0000_0000);  // miss on empty list
        send_request(plt_pkg::REQ_MODIFY, 7'd0,   32'h1111_1111);  // out of range, empty
        send_request(plt_pkg::REQ_REMOVE, 7'd0,   32'h0000_0000);  // out of range, empty
        send_request(plt_pkg::REQ_APPEND, 7'd127, 32'h8000_0000);
        send_request(plt_pkg::REQ_APPEND, 7'd0,   32'h7fff_ffff);
        send_request(plt_pkg::REQ_APPEND, 7'd0,   32'h0000_0000);
        send_request(plt_pkg::REQ_APPEND, 7'd0,   32'hffff_ffff);
        send_request(plt_pkg::REQ_APPEND, 7'd0,   32'h7fff_ffff);  // duplicate value
        send_request(plt_pkg::REQ_FIND,   7'd0,   32'h7fff_ffff);  // lowest of two matches
        send_request(plt_pkg::REQ_FIND,   7'd127, 32'h8000_0000);
        send_request(plt_pkg::REQ_FIND,   7'd0,   32'h1234_5678);  // miss
        send_request(plt_pkg::REQ_MODIFY, 7'd4,   32'h5a5a_5a5a);  // last valid position
        send_request(plt_pkg::REQ_MODIFY, 7'd5,   32'h0000_0001);  // position equal to count
        send_request(plt_pkg::REQ_MODIFY, 7'd127, 32'hffff_ffff);  // widest position
        send_request(plt_pkg::REQ_REMOVE, 7'd127, 32'h0000_0000);
        send_request(plt_pkg::REQ_REMOVE, 7'd0,   32'h0000_0000);  // head, all shift down
        send_request(plt_pkg::REQ_REMOVE, 7'd3,   32'h0000_0000);  // tail, nothing shifts
        send_request(plt_pkg::REQ_FIND,   7'd0,   32'hffff_ffff);
        send_request(plt_pkg::REQ_FIND,   7'd0,   32'h5a5a_5a5a);  // removed value, miss
        send_request(plt_pkg::REQ_REMOVE, 7'd1,   32'h0000_0000);
        send_request(plt_pkg::REQ_REMOVE, 7'd0,   32'h0000_0000);
        send_request(plt_pkg::REQ_REMOVE, 7'd0,   32'h0000_0000);  // list empty again
        send_request(plt_pkg::REQ_APPEND, 7'd85,  32'haaaa_aaaa);
        send_request(plt_pkg::REQ_MODIFY, 7'd0,   32'h5555_5555);

        // random: fill and drain blocks reach the full and empty corners
        for (phase = 0; phase < 4; phase++) begin
            pause_until_drained();
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 73; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 73; end
                default: begin send_idle_pct = 28; recv_stall_pct = 28; end
            endcase
            @(negedge i_clk);
            for (n = 0; n < RAND_PER_PHASE; n++) begin
                // long receiver hold-off while the sender keeps offering
                if (phase == 0 && n == 120) begin
                    i_in_valid <= 1'b0;
                    @(posedge i_clk);
                    hold_request = 1'b1;
                    @(negedge i_clk);
                end
                regime = (n / BLOCK_LEN) % 5;
                roll   = $urandom_range(99);
                if (regime <= 1) begin
                    // filling: mostly appends
                    if (roll < 85)      req = plt_pkg::REQ_APPEND;
                    else if (roll < 90) req = plt_pkg::REQ_FIND;
                    else if (roll < 95) req = plt_pkg::REQ_MODIFY;
                    else                req = plt_pkg::REQ_REMOVE;
                end else if (regime == 2) begin
                    req = plt_pkg::t_req'(roll / 25);
                end else begin
                    // draining: mostly removes
                    if (roll < 80)      req = plt_pkg::REQ_REMOVE;
                    else if (roll < 88) req = plt_pkg::REQ_FIND;
                    else if (roll < 95) req = plt_pkg::REQ_MODIFY;
                    else                req = plt_pkg::REQ_APPEND;
                end
                count = sb.occupancy();
                if (count > 0 && $urandom_range(99) < 85) begin
                    pos = 7'($urandom_range(count - 1));
                end else begin
                    pos = 7'($urandom_range(127));
                end
                // a small pool of values keeps finds hitting and duplicates common
                if ($urandom_range(99) < 60) begin
                    val = value_pool[$urandom_range(POOL_SIZE - 1)];
                end else begin
                    val = $urandom();
                end
                send_request(req, pos, val);
            end
        end

        pause_until_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
hw/rtl/plt_pkg.sv
hw/rtl/plt_cell.sv
hw/rtl/plt_group.sv
hw/rtl/packed_list_table_top.sv
tb/packed_list_table_top_tb.sv
